[hw/rtl/wvad_pkg.sv]
`default_nettype none

package wvad_pkg;

  // window depth default, field widths and percent scale constants
  localparam int unsigned WINDOW_DEPTH_DEF = 12;
  localparam int unsigned THR_W            = 4;
  localparam int unsigned RATIO_W          = 7;
  localparam int unsigned TIME_W           = 32;
  localparam int unsigned CNT_OUT_W        = 4;
  localparam int unsigned PCT_W            = 7;
  localparam int unsigned STEP_W           = 3;
  localparam int unsigned PCT_SCALE        = 100;
  localparam int unsigned PCT_DOUBLE       = 200;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FILLED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CANDIDATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STRONG    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_PERCENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_MS    = 3'd4;

  localparam logic [THR_W-1:0]   RST_MIN_FILLED    = 4'd6;
  localparam logic [THR_W-1:0]   RST_MIN_CANDIDATE = 4'd3;
  localparam logic [THR_W-1:0]   RST_MIN_STRONG    = 4'd1;
  localparam logic [RATIO_W-1:0] RST_RATIO_PERCENT = 7'd25;
  localparam logic [TIME_W-1:0]  RST_HOLDOFF_MS    = 32'd7000;

  // item action codes
  localparam logic ACT_WINDOW = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef struct packed {
    logic              action;
    logic              candidate;
    logic              strong_req;
    logic [TIME_W-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic                 alert_now;
    logic                 raw_alert;
    logic [CNT_OUT_W-1:0] candidate_total;
    logic [CNT_OUT_W-1:0] strong_total;
    logic [CNT_OUT_W-1:0] filled_total;
    logic [PCT_W-1:0]     candidate_percent;
  } out_t;

  typedef struct packed {
    logic [THR_W-1:0]   min_filled_windows;
    logic [THR_W-1:0]   min_candidate_count;
    logic [THR_W-1:0]   min_strong_count;
    logic [RATIO_W-1:0] ratio_percent;
    logic [TIME_W-1:0]  holdoff_ms;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic eval;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/wvad_ctrl.sv]
`default_nettype none

module wvad_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wvad_pkg::status_t      status_i,
  output wvad_pkg::cmd_t         cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = status_i.is_clear ? S_IDLE : S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/wvad_dp.sv]
`default_nettype none

module wvad_dp #(
  parameter int unsigned WindowDepth = wvad_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wvad_pkg::in_t          in_i,
  input  wvad_pkg::cfg_t         cfg_i,
  input  wvad_pkg::cmd_t         cmd_i,
  output wvad_pkg::status_t      status_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output wvad_pkg::out_t         out_o
);

  localparam int unsigned SLOT_W = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned CNT_W  = $clog2(WindowDepth + 1);
  localparam int unsigned THR_CW = (CNT_W > wvad_pkg::THR_W) ? CNT_W : wvad_pkg::THR_W;
  localparam int unsigned NUM_W  = $clog2(WindowDepth * (wvad_pkg::PCT_DOUBLE + 1) + 1);
  localparam int unsigned DEN_W  = CNT_W + 1;
  localparam int unsigned DSH_W  = DEN_W + wvad_pkg::PCT_W - 1;
  localparam int unsigned CMP_W  = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int unsigned PROD_W = CNT_W + wvad_pkg::RATIO_W;
  localparam int unsigned T_W    = wvad_pkg::TIME_W;
  localparam int unsigned P_W    = wvad_pkg::PCT_W;

  wvad_pkg::in_t          item_q;
  logic [WindowDepth-1:0] cand_ring_q, strong_ring_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [CNT_W-1:0]       filled_q, cand_cnt_q, strong_cnt_q;
  logic [T_W-1:0]         last_alert_q;
  logic                   raw_q, alert_q;
  logic [NUM_W-1:0]       rem_q;
  logic [DSH_W-1:0]       dsh_q;
  logic [P_W-1:0]         quot_q;
  logic [wvad_pkg::STEP_W-1:0] step_q;
  logic                   out_full_q;
  wvad_pkg::out_t         out_q;

  // ring update terms
  logic             old_cand, old_strong;
  logic [SLOT_W-1:0] slot_nxt;

  // rule terms
  logic              by_strong, by_ratio, raw, held, alert;
  logic [PROD_W-1:0] cand_scaled, ratio_scaled;
  logic [T_W-1:0]    since_last;

  // divider terms
  logic [CMP_W-1:0] rem_ext, dsh_ext;
  logic             div_ge;

  assign old_cand   = cand_ring_q[slot_q];
  assign old_strong = strong_ring_q[slot_q];
  assign slot_nxt   = (slot_q == SLOT_W'(WindowDepth - 1)) ? '0 : slot_q + SLOT_W'(1);

  assign cand_scaled  = PROD_W'(cand_cnt_q) * PROD_W'(wvad_pkg::PCT_SCALE);
  assign ratio_scaled = PROD_W'(cfg_i.ratio_percent) * PROD_W'(filled_q);
  assign by_strong    = THR_CW'(strong_cnt_q) >= THR_CW'(cfg_i.min_strong_count);
  assign by_ratio     = (THR_CW'(filled_q) >= THR_CW'(cfg_i.min_filled_windows)) &&
                        (THR_CW'(cand_cnt_q) >= THR_CW'(cfg_i.min_candidate_count)) &&
                        (cand_scaled >= ratio_scaled);
  assign raw          = by_strong || by_ratio;
  assign since_last   = item_q.now_ms - last_alert_q;
  assign held         = (last_alert_q != '0) && (since_last < cfg_i.holdoff_ms);
  assign alert        = raw && !held;

  assign rem_ext = CMP_W'(rem_q);
  assign dsh_ext = CMP_W'(dsh_q);
  assign div_ge  = rem_ext >= dsh_ext;

  assign status_o.is_clear = (item_q.action == wvad_pkg::ACT_CLEAR);
  assign status_o.div_last = (step_q == wvad_pkg::STEP_W'(P_W - 1));
  assign status_o.out_free = !out_full_q || !out_stall_i;

  assign out_valid_o = out_full_q;
  assign out_o       = out_q;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_i;
    end
    if (cmd_i.eval) begin
      raw_q   <= raw;
      alert_q <= alert;
      rem_q   <= NUM_W'(cand_cnt_q) * NUM_W'(wvad_pkg::PCT_DOUBLE) + NUM_W'(filled_q);
      dsh_q   <= DSH_W'({filled_q, 1'b0}) << (P_W - 1);
      quot_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= NUM_W'(rem_ext - dsh_ext);
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[P_W-2:0], div_ge};
    end
    if (cmd_i.load_out) begin
      out_q.alert_now         <= alert_q;
      out_q.raw_alert         <= raw_q;
      out_q.candidate_total   <= wvad_pkg::CNT_OUT_W'(cand_cnt_q);
      out_q.strong_total      <= wvad_pkg::CNT_OUT_W'(strong_cnt_q);
      out_q.filled_total      <= wvad_pkg::CNT_OUT_W'(filled_q);
      out_q.candidate_percent <= quot_q;
    end
  end

  // history, counters, alert time, divider step, output flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_ring_q   <= '0;
      strong_ring_q <= '0;
      slot_q        <= '0;
      filled_q      <= '0;
      cand_cnt_q    <= '0;
      strong_cnt_q  <= '0;
      last_alert_q  <= '0;
      step_q        <= '0;
      out_full_q    <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        if (item_q.action == wvad_pkg::ACT_CLEAR) begin
          cand_ring_q   <= '0;
          strong_ring_q <= '0;
          slot_q        <= '0;
          filled_q      <= '0;
          cand_cnt_q    <= '0;
          strong_cnt_q  <= '0;
        end else begin
          // unfilled entries are always zero, so the running counts stay exact
          cand_ring_q[slot_q]   <= item_q.candidate;
          strong_ring_q[slot_q] <= item_q.strong_req;
          slot_q                <= slot_nxt;
          if (filled_q != CNT_W'(WindowDepth)) begin
            filled_q <= filled_q + CNT_W'(1);
          end
          cand_cnt_q   <= cand_cnt_q + CNT_W'(item_q.candidate) - CNT_W'(old_cand);
          strong_cnt_q <= strong_cnt_q + CNT_W'(item_q.strong_req) - CNT_W'(old_strong);
        end
      end
      if (cmd_i.eval) begin
        step_q <= '0;
        if (alert) begin
          last_alert_q <= item_q.now_ms;
        end
      end else if (cmd_i.div_step) begin
        step_q <= step_q + wvad_pkg::STEP_W'(1);
      end
      if (cmd_i.load_out) begin
        out_full_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_full_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/window_vote_alert_detector.sv]
`default_nettype none

// channel   direction  handshake                payload
// in        input      in_valid_i / in_stall_o   in_i  (wvad_pkg::in_t)
// out       output     out_valid_o / out_stall_i out_o (wvad_pkg::out_t)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// after acceptance a window beat goes through a ring update, a rule evaluation,
// a restoring divider step per quotient bit of the percent, and a load into the
// result register; a clear beat only empties the ring and counts in its update
// step; the next beat is taken once back in idle; reset empties the ring and
// the alert time and loads register defaults; under out stall a finished beat
// waits in the output register and the next result waits in the controller

module window_vote_alert_detector #(
  parameter int unsigned WindowDepth = wvad_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // window and clear beats
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wvad_pkg::in_t                          in_i,
  // result beats
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output wvad_pkg::out_t                         out_o,
  // register writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [wvad_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [wvad_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  wvad_pkg::cfg_t    cfg_q;
  wvad_pkg::cmd_t    cmd;
  wvad_pkg::status_t status;

  // writes come only while idle, a rule on the user that the block does not enforce; the port never pushes back
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_filled_windows  <= wvad_pkg::RST_MIN_FILLED;
      cfg_q.min_candidate_count <= wvad_pkg::RST_MIN_CANDIDATE;
      cfg_q.min_strong_count    <= wvad_pkg::RST_MIN_STRONG;
      cfg_q.ratio_percent       <= wvad_pkg::RST_RATIO_PERCENT;
      cfg_q.holdoff_ms          <= wvad_pkg::RST_HOLDOFF_MS;
    end else if (cfg_valid_i) begin
      // unknown indexes are dropped
      unique case (cfg_index_i)
        wvad_pkg::CFG_MIN_FILLED: begin
          cfg_q.min_filled_windows <= cfg_data_i[wvad_pkg::THR_W-1:0];
        end
        wvad_pkg::CFG_MIN_CANDIDATE: begin
          cfg_q.min_candidate_count <= cfg_data_i[wvad_pkg::THR_W-1:0];
        end
        wvad_pkg::CFG_MIN_STRONG: begin
          cfg_q.min_strong_count <= cfg_data_i[wvad_pkg::THR_W-1:0];
        end
        wvad_pkg::CFG_RATIO_PERCENT: begin
          cfg_q.ratio_percent <= cfg_data_i[wvad_pkg::RATIO_W-1:0];
        end
        wvad_pkg::CFG_HOLDOFF_MS: begin
          cfg_q.holdoff_ms <= cfg_data_i[wvad_pkg::TIME_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer: capture, update, evaluate, divide, load
  wvad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // ring, running counts, rules, holdoff timer, percent divider, output register
  wvad_dp #(
    .WindowDepth (WindowDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
